FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/mqs_pkg.sv
`timescale 1ns / 1ps
package mqs_pkg;

  localparam int TIME_W = 16;
  localparam int PRIO_W = 4;
  localparam int BURST_W = 16;
  localparam int RUN_ID_W = 7;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] CFG_RR_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_QUEUE_BUDGET = 2'd1;
  localparam logic [1:0] CFG_BAND_ONE_TOP = 2'd2;
  localparam logic [1:0] CFG_BAND_TWO_TOP = 2'd3;

  localparam logic [3:0] RST_RR_QUANTUM = 4'd4;
  localparam logic [7:0] RST_QUEUE_BUDGET = 8'd10;
  localparam logic [3:0] RST_BAND_ONE_TOP = 4'd3;
  localparam logic [3:0] RST_BAND_TWO_TOP = 4'd6;

  // queue numbers as held in the phase register
  localparam logic [1:0] PH_RR = 2'd0;
  localparam logic [1:0] PH_PRIO = 2'd1;
  localparam logic [1:0] PH_FCFS = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0]  arrival;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] rem;
  } tab_word_t;

endpackage

FILE: rtl/core/mqs_ram.sv
`timescale 1ns / 1ps
module mqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/core/multilevel_queue_scheduler.sv
`timescale 1ns / 1ps
// Multilevel-queue scheduler.
// Input requests: in_tuser = kind (0 load a process, 1 advance one tick),
// in_tdata = arrival_time, priority_req, burst_length from bit 0 up.
// Every request yields exactly one result on the out_ channel.
// Loads fill the process table (process k = k-th accepted load); a load
// after the first tick or into a full table is flagged load_rejected.
// Ticks run queue 1 round robin, queue 2 by priority, queue 3 in order.
// A tick first skips empty or spent queues, runs the head of the selected
// queue, then advances time and scans the table for arrivals; the first
// tick also scans once before selecting, and a process sorted into queue 2
// shifts larger priorities back one by one. An idle tick only advances
// time and scans. The table RAM read port is registered, so each scanned
// entry takes a read state and a check state. in_tready is high only while
// the sequencer idles.
// A finished result sits in the output register; the next request is taken
// meanwhile, and the block waits before posting its result while the
// receiver stalls. Reset (rst_n low, synchronous) empties all queues and
// the table, loads the register defaults; no clearing pass is needed.
module multilevel_queue_scheduler #(
  parameter int MAX_PROCESSES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // arrival_time[15:0], priority_req[19:16], burst_length[35:20]
  input  logic [39:0] in_tdata,
  // kind
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // running_id[6:0], queue_served[8:7], remaining_burst[24:9],
  // time_now[40:25], finished[41], all_done[42], load_rejected[43]
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int IDXW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNTW = $clog2(MAX_PROCESSES + 1);
  localparam int SW = CNTW + 1;
  localparam int SLW = IDXW + mqs_pkg::PRIO_W;
  localparam int TABW = $bits(mqs_pkg::tab_word_t);
  localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_PROCESSES);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_INS_RD, S_INS_CHK, S_INS_PUT,
    S_SEL, S_HEAD_RD, S_TAB_RD, S_RUN, S_ADV, S_ROT, S_OUT
  } state_t;

  // ring index: base + off, folded once (off <= MAX)
  function automatic logic [IDXW-1:0] wrap_add(input logic [IDXW-1:0] base,
                                               input logic [CNTW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(MAX_PROCESSES)) begin
      s = s - SW'(MAX_PROCESSES);
    end
    return s[IDXW-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic started_r, started_nxt;
  logic [CNTW-1:0] loaded_r, loaded_nxt;
  logic [CNTW-1:0] unfin_r, unfin_nxt;       // loaded processes with work left
  logic [15:0] time_r, time_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] pt_r, pt_nxt;
  logic [3:0] qt_r, qt_nxt;
  logic [IDXW-1:0] head_r [3];
  logic [IDXW-1:0] head_nxt [3];
  logic [CNTW-1:0] cnt_r [3];
  logic [CNTW-1:0] cnt_nxt [3];
  logic [CNTW-1:0] scan_i_r, scan_i_nxt;
  logic [15:0] scan_t_r, scan_t_nxt;
  logic scan_ret_r, scan_ret_nxt;           // 1: scan came from time advance
  logic [3:0] ins_prio_r, ins_prio_nxt;
  logic [CNTW-1:0] ins_k_r, ins_k_nxt;
  logic [1:0] run_q_r, run_q_nxt;
  logic [IDXW-1:0] run_idx_r, run_idx_nxt;
  logic [3:0] run_prio_r, run_prio_nxt;
  logic run_act_r, run_act_nxt;
  logic [6:0] res_run_r, res_run_nxt;
  logic [1:0] res_srv_r, res_srv_nxt;
  logic [15:0] res_rem_r, res_rem_nxt;
  logic res_fin_r, res_fin_nxt;
  logic res_rej_r, res_rej_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic [3:0] quant_r, quant_nxt;
  logic [7:0] budget_r, budget_nxt;
  logic [3:0] b1_r, b1_nxt;
  logic [3:0] b2_r, b2_nxt;

  // table RAM
  logic tab_we;
  logic [IDXW-1:0] tab_waddr, tab_raddr;
  mqs_pkg::tab_word_t tab_wdata, tab_rd;
  logic [TABW-1:0] tab_rdata;

  // queue slot RAMs, one per queue, shared address/data
  logic [2:0] q_we;
  logic [IDXW-1:0] q_waddr, q_raddr;
  logic [SLW-1:0] q_wdata;
  logic [SLW-1:0] q_rdata [3];

  logic [7:0] budget_eff;
  logic [3:0] quant_eff;

  mqs_ram #(.WIDTH(TABW), .DEPTH(MAX_PROCESSES)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  for (genvar g = 0; g < 3; g++) begin : g_q
    mqs_ram #(.WIDTH(SLW), .DEPTH(MAX_PROCESSES)) u_slots (
      .clk(clk), .we(q_we[g]), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata[g])
    );
  end

  assign tab_rd = mqs_pkg::tab_word_t'(tab_rdata);
  assign budget_eff = (budget_r == 8'd0) ? 8'd1 : budget_r;
  assign quant_eff = (quant_r == 4'd0) ? 4'd1 : quant_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_comb begin
    logic [15:0] nr;
    logic [SLW-1:0] sd;
    nr = '0;
    sd = '0;
    state_nxt = state_r;
    started_nxt = started_r;
    loaded_nxt = loaded_r;
    unfin_nxt = unfin_r;
    time_nxt = time_r;
    phase_nxt = phase_r;
    pt_nxt = pt_r;
    qt_nxt = qt_r;
    head_nxt = head_r;
    cnt_nxt = cnt_r;
    scan_i_nxt = scan_i_r;
    scan_t_nxt = scan_t_r;
    scan_ret_nxt = scan_ret_r;
    ins_prio_nxt = ins_prio_r;
    ins_k_nxt = ins_k_r;
    run_q_nxt = run_q_r;
    run_idx_nxt = run_idx_r;
    run_prio_nxt = run_prio_r;
    run_act_nxt = run_act_r;
    res_run_nxt = res_run_r;
    res_srv_nxt = res_srv_r;
    res_rem_nxt = res_rem_r;
    res_fin_nxt = res_fin_r;
    res_rej_nxt = res_rej_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    quant_nxt = quant_r;
    budget_nxt = budget_r;
    b1_nxt = b1_r;
    b2_nxt = b2_r;
    tab_we = 1'b0;
    tab_waddr = run_idx_r;
    tab_wdata = tab_rd;
    tab_raddr = scan_i_r[IDXW-1:0];
    q_we = 3'b000;
    q_waddr = head_r[0];
    q_wdata = '0;
    q_raddr = head_r[0];

    if (cfg_we) begin
      case (cfg_index)
        mqs_pkg::CFG_RR_QUANTUM:   quant_nxt = cfg_wdata[3:0];
        mqs_pkg::CFG_QUEUE_BUDGET: budget_nxt = cfg_wdata;
        mqs_pkg::CFG_BAND_ONE_TOP: b1_nxt = cfg_wdata[3:0];
        mqs_pkg::CFG_BAND_TWO_TOP: b2_nxt = cfg_wdata[3:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_run_nxt = '0;
          res_srv_nxt = '0;
          res_rem_nxt = '0;
          res_fin_nxt = 1'b0;
          res_rej_nxt = 1'b0;
          run_act_nxt = 1'b0;
          if (in_tuser == mqs_pkg::KIND_LOAD) begin
            if (started_r || loaded_r == MAXC) begin
              res_rej_nxt = 1'b1;
            end else begin
              tab_we = 1'b1;
              tab_waddr = loaded_r[IDXW-1:0];
              tab_wdata.arrival = in_tdata[15:0];
              tab_wdata.prio = in_tdata[19:16];
              tab_wdata.rem = in_tdata[35:20];
              loaded_nxt = loaded_r + 1'b1;
              if (in_tdata[35:20] != 16'd0) begin
                unfin_nxt = unfin_r + 1'b1;
              end
            end
            state_nxt = S_OUT;
          end else if (!started_r) begin
            started_nxt = 1'b1;
            scan_t_nxt = time_r;
            scan_i_nxt = '0;
            scan_ret_nxt = 1'b0;
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_SEL;
          end
        end
      end

      S_SCAN_RD: begin
        if (scan_i_r >= loaded_r) begin
          state_nxt = scan_ret_r ? S_ROT : S_SEL;
        end else begin
          tab_raddr = scan_i_r[IDXW-1:0];
          state_nxt = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        scan_i_nxt = scan_i_r + 1'b1;
        state_nxt = S_SCAN_RD;
        q_wdata = {tab_rd.prio, scan_i_r[IDXW-1:0]};
        if (tab_rd.arrival == scan_t_r && tab_rd.rem != 16'd0) begin
          if (tab_rd.prio <= b1_r) begin
            if (cnt_r[0] != MAXC) begin
              q_we[0] = 1'b1;
              q_waddr = wrap_add(head_r[0], cnt_r[0]);
              cnt_nxt[0] = cnt_r[0] + 1'b1;
            end
          end else if (tab_rd.prio <= b2_r) begin
            ins_prio_nxt = tab_rd.prio;
            if (cnt_r[1] == '0) begin
              q_we[1] = 1'b1;
              q_waddr = head_r[1];
              cnt_nxt[1] = cnt_r[1] + 1'b1;
            end else if (cnt_r[1] != MAXC) begin
              // walk from the tail, shifting larger priorities back
              ins_k_nxt = cnt_r[1] - 1'b1;
              scan_i_nxt = scan_i_r;
              state_nxt = S_INS_RD;
            end
          end else begin
            if (cnt_r[2] != MAXC) begin
              q_we[2] = 1'b1;
              q_waddr = wrap_add(head_r[2], cnt_r[2]);
              cnt_nxt[2] = cnt_r[2] + 1'b1;
            end
          end
        end
      end

      S_INS_RD: begin
        q_raddr = wrap_add(head_r[1], ins_k_r);
        state_nxt = S_INS_CHK;
      end

      S_INS_CHK: begin
        sd = q_rdata[1];
        if (sd[SLW-1:IDXW] > ins_prio_r) begin
          q_we[1] = 1'b1;
          q_waddr = wrap_add(head_r[1], ins_k_r + 1'b1);
          q_wdata = sd;
          if (ins_k_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            ins_k_nxt = ins_k_r - 1'b1;
            state_nxt = S_INS_RD;
          end
        end else begin
          ins_k_nxt = ins_k_r + 1'b1;
          state_nxt = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        q_we[1] = 1'b1;
        q_waddr = wrap_add(head_r[1], ins_k_r);
        q_wdata = {ins_prio_r, scan_i_r[IDXW-1:0]};
        cnt_nxt[1] = cnt_r[1] + 1'b1;
        scan_i_nxt = scan_i_r + 1'b1;
        state_nxt = S_SCAN_RD;
      end

      S_SEL: begin
        if (cnt_r[0] == '0 && cnt_r[1] == '0 && cnt_r[2] == '0) begin
          phase_nxt = mqs_pkg::PH_RR;
          pt_nxt = '0;
          qt_nxt = '0;
          state_nxt = S_ADV;
        end else if (cnt_r[phase_r] != '0 && pt_r < budget_eff) begin
          run_q_nxt = phase_r;
          state_nxt = S_HEAD_RD;
        end else begin
          phase_nxt = (phase_r == mqs_pkg::PH_FCFS) ? mqs_pkg::PH_RR : phase_r + 1'b1;
          pt_nxt = '0;
          qt_nxt = '0;
        end
      end

      S_HEAD_RD: begin
        q_raddr = head_r[run_q_r];
        state_nxt = S_TAB_RD;
      end

      S_TAB_RD: begin
        sd = q_rdata[run_q_r];
        run_idx_nxt = sd[IDXW-1:0];
        tab_raddr = sd[IDXW-1:0];
        state_nxt = S_RUN;
      end

      S_RUN: begin
        nr = (tab_rd.rem != 16'd0) ? tab_rd.rem - 1'b1 : 16'd0;
        tab_we = 1'b1;
        tab_waddr = run_idx_r;
        tab_wdata.rem = nr;
        run_prio_nxt = tab_rd.prio;
        run_act_nxt = 1'b1;
        res_run_nxt = 7'(SW'(run_idx_r) + 1'b1);
        res_srv_nxt = run_q_r + 1'b1;
        res_rem_nxt = nr;
        pt_nxt = pt_r + 1'b1;
        if (run_q_r == mqs_pkg::PH_RR) begin
          qt_nxt = qt_r + 1'b1;
        end
        if (nr == 16'd0) begin
          res_fin_nxt = 1'b1;
          head_nxt[run_q_r] = wrap_add(head_r[run_q_r], CNTW'(1));
          cnt_nxt[run_q_r] = cnt_r[run_q_r] - 1'b1;
          if (run_q_r == mqs_pkg::PH_RR) begin
            qt_nxt = '0;
          end
          if (tab_rd.rem != 16'd0) begin
            unfin_nxt = unfin_r - 1'b1;
          end
        end
        state_nxt = S_ADV;
      end

      S_ADV: begin
        if (time_r != mqs_pkg::TIME_MAX) begin
          time_nxt = time_r + 1'b1;
          scan_t_nxt = time_r + 1'b1;
          scan_i_nxt = '0;
          scan_ret_nxt = 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_ROT;
        end
      end

      S_ROT: begin
        // quantum used up: pop the head and push it at the tail
        if (run_act_r && run_q_r == mqs_pkg::PH_RR && !res_fin_r && qt_r >= quant_eff) begin
          q_we[0] = 1'b1;
          q_waddr = wrap_add(head_r[0], cnt_r[0]);
          q_wdata = {run_prio_r, run_idx_r};
          head_nxt[0] = wrap_add(head_r[0], CNTW'(1));
          qt_nxt = '0;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {4'b0000, res_rej_r, (unfin_r == '0), res_fin_r, time_r,
                          res_rem_r, res_srv_r, res_run_r};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      started_r <= 1'b0;
      loaded_r <= '0;
      unfin_r <= '0;
      time_r <= '0;
      phase_r <= mqs_pkg::PH_RR;
      pt_r <= '0;
      qt_r <= '0;
      head_r <= '{default: '0};
      cnt_r <= '{default: '0};
      scan_i_r <= '0;
      scan_ret_r <= 1'b0;
      run_act_r <= 1'b0;
      out_valid_r <= 1'b0;
      quant_r <= mqs_pkg::RST_RR_QUANTUM;
      budget_r <= mqs_pkg::RST_QUEUE_BUDGET;
      b1_r <= mqs_pkg::RST_BAND_ONE_TOP;
      b2_r <= mqs_pkg::RST_BAND_TWO_TOP;
    end else begin
      state_r <= state_nxt;
      started_r <= started_nxt;
      loaded_r <= loaded_nxt;
      unfin_r <= unfin_nxt;
      time_r <= time_nxt;
      phase_r <= phase_nxt;
      pt_r <= pt_nxt;
      qt_r <= qt_nxt;
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
      scan_i_r <= scan_i_nxt;
      scan_ret_r <= scan_ret_nxt;
      run_act_r <= run_act_nxt;
      out_valid_r <= out_valid_nxt;
      quant_r <= quant_nxt;
      budget_r <= budget_nxt;
      b1_r <= b1_nxt;
      b2_r <= b2_nxt;
    end
    scan_t_r <= scan_t_nxt;
    ins_prio_r <= ins_prio_nxt;
    ins_k_r <= ins_k_nxt;
    run_q_r <= run_q_nxt;
    run_idx_r <= run_idx_nxt;
    run_prio_r <= run_prio_nxt;
    res_run_r <= res_run_nxt;
    res_srv_r <= res_srv_nxt;
    res_rem_r <= res_rem_nxt;
    res_fin_r <= res_fin_nxt;
    res_rej_r <= res_rej_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: rtl/core/mqs_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mqs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // stalled result stays up
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // one request at a time: busy right after an accept
  `ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // no queue served means nothing ran
  `ASSERT_IMPL(a_idle_fields, clk, rst_n, out_tvalid && out_tdata[8:7] == 2'd0,
    out_tdata[6:0] == 7'd0 && out_tdata[24:9] == 16'd0 && !out_tdata[41])
  // completion only with zero work left on a served queue
  `ASSERT_IMPL(a_fin, clk, rst_n, out_tvalid && out_tdata[41],
    out_tdata[24:9] == 16'd0 && out_tdata[8:7] != 2'd0)
  // a rejected load never runs anything
  `ASSERT_IMPL(a_rej, clk, rst_n, out_tvalid && out_tdata[43], out_tdata[8:7] == 2'd0)

endmodule

bind multilevel_queue_scheduler mqs_chk u_mqs_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
